// ===== src/gpdu_pkg.sv =====
// Package for the GNSS pulse-disciplined UTC seconds clock.
// Holds shared types, constants and the calendar table. No dependencies.
package gpdu_pkg;

  localparam int unsigned MsWidth = 32;

  localparam logic [31:0] MinPollMs  = 32'd20;
  localparam logic [31:0] SyncGapMs  = 32'd11111;
  localparam logic [15:0] MaxAgeMs   = 16'd2500;
  localparam logic [31:0] SecondMs   = 32'd1000;
  localparam logic [31:0] SimCorrMs  = 32'd200;
  localparam logic [31:0] LatePpsMs  = 32'd100;
  localparam logic [31:0] EarlyPpsMs = 32'd25;
  localparam logic [31:0] SecsPerDay = 32'd86400;
  // ceil(2^38 / 1000): exact ms-to-seconds quotient for any 32-bit count
  localparam logic [28:0] MsDivMagic = 29'd274877907;

  typedef enum logic [2:0] {
    CFG_PROTOCOL = 3'd0,
    CFG_SIMULATE = 3'd1,
    CFG_LATE_PPS = 3'd2,
    CFG_DELAY    = 3'd3,
    CFG_LEAP     = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DAYS,
    ST_SECS,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic days;
    logic secs;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic sync;
  } status_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        fix_ready;
    logic [15:0] fix_age_ms;
    logic [31:0] pps_mark_ms;
    logic [31:0] commit_ms;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } poll_t;

  typedef struct packed {
    logic [31:0] utc_seconds;
    logic [31:0] ref_ms;
    logic        synced;
  } res_t;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    begin
      case (m)
        4'd0:    r = 9'd0;
        4'd1:    r = 9'd31;
        4'd2:    r = 9'd59;
        4'd3:    r = 9'd90;
        4'd4:    r = 9'd120;
        4'd5:    r = 9'd151;
        4'd6:    r = 9'd181;
        4'd7:    r = 9'd212;
        4'd8:    r = 9'd243;
        4'd9:    r = 9'd273;
        4'd10:   r = 9'd304;
        4'd11:   r = 9'd334;
        default: r = 9'd365;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== src/gpdu_if.sv =====
// Valid/ready channel interface carrying one payload word.
// Generic in payload type; no package dependency.
interface gpdu_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/gpdu_cfg_if.sv =====
// Configuration write channel: register index and write data.
// No dependencies.
interface gpdu_cfg_if ();
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== src/gpdu_ctrl.sv =====
// Sequencer for one poll: load, decide, then (on sync only) calendar days, seconds, finish; output.
// Depends on gpdu_pkg.
module gpdu_ctrl import gpdu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: state_next = status.sync ? ST_DAYS : ST_OUT;
      ST_DAYS:   state_next = ST_SECS;
      ST_SECS:   state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:   begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_DECIDE: cmd.decide = 1'b1;
      ST_DAYS:   cmd.days = 1'b1;
      ST_SECS:   cmd.secs = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      ST_OUT:    out_valid = 1'b1;
      default:   ;
    endcase
  end
endmodule

// ===== src/gpdu_dp.sv =====
// Datapath: clock state, fix checks and calendar-to-seconds conversion.
// Depends on gpdu_pkg.
module gpdu_dp import gpdu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  poll_t       poll,
  input  logic        protocol_enabled,
  input  logic        simulate_mode,
  input  logic        late_pps_module,
  input  logic [9:0]  assumed_delay_ms,
  input  logic [7:0]  leap_offset,
  output status_t     status,
  output res_t        res
);
  logic [31:0] seconds_count, second_start_ms, last_sync_base_ms;
  logic [31:0] last_poll_ms, last_sync_poll_ms;
  logic        fix_pending, synced;
  poll_t       p;
  logic [31:0] corr, days, secs;
  logic [7:0]  yoff;
  logic        leap_y;
  logic        poll_due;
  logic [60:0] div_prod;
  logic [22:0] now_sec;

  // decide-step combinational values
  logic [31:0] d_ss, d_pps, d_commit, d_corr, d_newtime, d_pps_s;
  logic        d_fix, d_go, d_free;
  logic [31:0] d_ss_run, d_sec_run;

  // whole seconds of the poll time, taken when the word is loaded
  assign div_prod = 61'(poll.now_ms) * 61'(MsDivMagic);
  assign poll_due = !(p.now_ms - last_poll_ms < MinPollMs);

  always_comb begin
    d_fix = fix_pending;
    d_ss = second_start_ms;
    d_commit = p.commit_ms;
    d_pps = '0;
    d_pps_s = '0;
    d_corr = '0;
    d_newtime = '0;
    d_go = 1'b0;
    d_free = 1'b0;
    if (simulate_mode) begin
      if (d_ss == '0) d_ss = 32'(now_sec) * SecondMs;
      d_pps_s = d_ss;
      if (d_commit < d_pps_s) d_pps_s = d_pps_s - SecondMs;
      d_corr = (d_commit < d_pps_s) ? SimCorrMs : d_commit - d_pps_s;
      d_go = d_fix;
      d_free = !d_fix;
    end else begin
      if (d_commit == '0) d_commit = p.now_ms;
      d_pps = p.pps_mark_ms;
      if (d_pps != '0) begin
        if (d_commit < d_pps) d_pps = d_pps - SecondMs;
        d_newtime = late_pps_module ? d_pps - LatePpsMs : d_pps + EarlyPpsMs;
        d_corr = d_commit - d_pps;
      end else begin
        d_corr = {22'd0, assumed_delay_ms};
        d_newtime = d_commit - d_corr;
      end
      d_go = d_fix && p.fix_age_ms < MaxAgeMs && d_newtime > last_sync_base_ms
             && (d_pps == '0 || d_commit > d_pps)
             && !(p.now_ms - last_sync_poll_ms < SyncGapMs);
      if (d_go && d_pps != '0 && p.now_ms > d_pps + SecondMs)
        d_newtime = d_newtime + SecondMs;
      d_free = !d_go && d_ss != '0;
    end
    d_ss_run = d_ss;
    d_sec_run = seconds_count;
    if (d_free && p.now_ms >= d_ss + SecondMs) begin
      d_ss_run = d_ss + SecondMs;
      d_sec_run = seconds_count + 32'd1;
    end
  end

  logic [11:0] yr;
  logic [11:0] yy, pm1;
  logic [31:0] lb;
  logic [3:0]  mon;
  // years span 1970..2225: only 2100 and 2200 are century non-leap years
  always_comb begin
    yr = p.year_in;
    yoff = (yr > 12'd99) ? 8'(yr - 12'd1970) : 8'(yr + 12'd30);
    yy = 12'd1970 + 12'(yoff);
    pm1 = yy - 12'd1;
    lb = 32'(pm1 >> 2) - 32'd492 - 32'(pm1 >= 12'd2100) - 32'(pm1 >= 12'd2200);
    leap_y = (yy[1:0] == 2'b00) && (yy != 12'd2100) && (yy != 12'd2200);
    mon = (p.month_in > 4'd13) ? 4'd13 : p.month_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count <= '0;
      second_start_ms <= '0;
      last_sync_base_ms <= '0;
      last_poll_ms <= '0;
      last_sync_poll_ms <= '0;
      fix_pending <= 1'b0;
      synced <= 1'b0;
    end else begin
      if (cmd.load) begin
        p <= poll;
        now_sec <= div_prod[60:38];
        synced <= 1'b0;
        if (poll.fix_ready) fix_pending <= 1'b1;
      end
      if (cmd.decide) begin
        if (poll_due) begin
          last_poll_ms <= p.now_ms;
          if (protocol_enabled) begin
            fix_pending <= 1'b0;
            corr <= d_corr;
            if (d_go) begin
              if (!simulate_mode) begin
                second_start_ms <= d_newtime;
                last_sync_base_ms <= d_newtime;
              end else begin
                second_start_ms <= d_ss;
              end
            end else begin
              second_start_ms <= d_ss_run;
              seconds_count <= d_sec_run;
            end
          end
        end
      end
      if (cmd.days) begin
        days <= 32'(yoff) * 32'd365 + lb + 32'(month_start(mon - 4'd1) & {9{mon != 4'd0}})
                + 32'(mon > 4'd2 && leap_y) + 32'(p.day_in) - 32'd1;
        secs <= 32'(p.hour_in) * 32'd3600 + 32'(p.minute_in) * 32'd60 + 32'(p.second_in);
      end
      if (cmd.secs) days <= days * SecsPerDay + secs;
      if (cmd.finish) begin
        seconds_count <= days + 32'(({16'd0, p.fix_age_ms} + {1'b0, corr}) >= 33'd1000)
                         - {{24{leap_offset[7]}}, leap_offset};
        last_sync_poll_ms <= p.now_ms;
        synced <= 1'b1;
      end
    end
  end

  assign status.sync = poll_due && protocol_enabled && d_go;
  assign res.utc_seconds = seconds_count;
  assign res.ref_ms = second_start_ms;
  assign res.synced = synced;
endmodule

// ===== src/gnss_pps_disciplined_utc_clock.sv =====
// GNSS pulse-disciplined UTC seconds clock, top level.
// One poll at a time: after acceptance the poll is decided and, when a fix is applied,
// runs calendar days, seconds and finish; the result stays valid until taken and the
// next poll is accepted the cycle after delivery. Calendar conversion is the long path.
// Synchronous active-high reset clears clock state and loads register defaults.
// Depends on gpdu_pkg, gpdu_if, gpdu_cfg_if, gpdu_ctrl, gpdu_dp.
module gnss_pps_disciplined_utc_clock import gpdu_pkg::*; (
  input logic clk,
  input logic rst,
  gpdu_if.sink       in_ch,
  gpdu_if.source     out_ch,
  gpdu_cfg_if.sink   cfg
);
  logic       protocol_enabled, simulate_mode, late_pps_module;
  logic [9:0] assumed_delay_ms;
  logic [7:0] leap_offset;
  cmd_t       cmd;
  status_t    status;
  res_t       res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_enabled <= 1'b1;
      simulate_mode <= 1'b0;
      late_pps_module <= 1'b0;
      assumed_delay_ms <= 10'd100;
      leap_offset <= 8'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PROTOCOL: protocol_enabled <= cfg.wdata[0];
        CFG_SIMULATE: simulate_mode <= cfg.wdata[0];
        CFG_LATE_PPS: late_pps_module <= cfg.wdata[0];
        CFG_DELAY:    assumed_delay_ms <= cfg.wdata;
        CFG_LEAP:     leap_offset <= cfg.wdata[7:0];
        default:      ;
      endcase
    end
  end

  gpdu_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status, .cmd
  );

  gpdu_dp u_dp (
    .clk, .rst, .cmd, .poll(in_ch.data),
    .protocol_enabled, .simulate_mode, .late_pps_module,
    .assumed_delay_ms, .leap_offset, .status, .res
  );

  assign out_ch.data = res;
endmodule
